// ----- rtl/camera_pose_view_matrix_defines.svh -----
`ifndef CAMERA_POSE_VIEW_MATRIX_DEFINES_SVH
`define CAMERA_POSE_VIEW_MATRIX_DEFINES_SVH

// check in the cycle after a condition, held off during reset
`define CVM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cvm check failed");

// check the cycle after reset
`define CVM_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("cvm reset check failed");

`endif

// ----- rtl/cvm_pkg.sv -----
package cvm_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int DIV_NUM_W    = 62;

   localparam logic signed [63:0] FX_ONE      = 64'sd1073741824;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic MODE_MOVE   = 1'b0;
   localparam logic MODE_ROTATE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RM_MUL, ST_RM_BUILD, ST_MV_MAC, ST_CS_START, ST_CS_WAIT, ST_QM_MAC,
      ST_NS_MAC, ST_SQ_START, ST_SQ_WAIT, ST_DV_START, ST_DV_WAIT, ST_TX_MAC, ST_DONE
   } state_type;

   typedef enum logic [1:0] {PH_YAW, PH_PITCH, PH_ROLL} phase_type;

   typedef struct packed {
      logic [1:0] ia;
      logic [1:0] ib;
      logic       neg;
   } term_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } cs_out_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sq_out_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } dv_out_type;

   function automatic logic [31:0] atan_val(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   // quaternion product terms, grouped four per output component w, x, y, z
   function automatic term_type qm_term(input logic [3:0] n);
      term_type t;
      unique case (n)
         4'd0:  t = '{2'd0, 2'd0, 1'b0};
         4'd1:  t = '{2'd1, 2'd1, 1'b1};
         4'd2:  t = '{2'd2, 2'd2, 1'b1};
         4'd3:  t = '{2'd3, 2'd3, 1'b1};
         4'd4:  t = '{2'd0, 2'd1, 1'b0};
         4'd5:  t = '{2'd1, 2'd0, 1'b0};
         4'd6:  t = '{2'd2, 2'd3, 1'b0};
         4'd7:  t = '{2'd3, 2'd2, 1'b1};
         4'd8:  t = '{2'd0, 2'd2, 1'b0};
         4'd9:  t = '{2'd1, 2'd3, 1'b1};
         4'd10: t = '{2'd2, 2'd0, 1'b0};
         4'd11: t = '{2'd3, 2'd1, 1'b0};
         4'd12: t = '{2'd0, 2'd3, 1'b0};
         4'd13: t = '{2'd1, 2'd2, 1'b0};
         4'd14: t = '{2'd2, 2'd1, 1'b1};
         4'd15: t = '{2'd3, 2'd0, 1'b0};
      endcase
      return t;
   endfunction

   // rotation matrix products: xx yy zz xy xz yz wx wy wz
   function automatic term_type rm_pair(input logic [3:0] n);
      term_type t;
      case (n)
         4'd0: t = '{2'd1, 2'd1, 1'b0};
         4'd1: t = '{2'd2, 2'd2, 1'b0};
         4'd2: t = '{2'd3, 2'd3, 1'b0};
         4'd3: t = '{2'd1, 2'd2, 1'b0};
         4'd4: t = '{2'd1, 2'd3, 1'b0};
         4'd5: t = '{2'd2, 2'd3, 1'b0};
         4'd6: t = '{2'd0, 2'd1, 1'b0};
         4'd7: t = '{2'd0, 2'd2, 1'b0};
         4'd8: t = '{2'd0, 2'd3, 1'b0};
         default: t = '{2'd0, 2'd0, 1'b0};
      endcase
      return t;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// ----- rtl/camera_pose_view_matrix.sv -----
// channel  | dir | tdata (low bit up)                                   | tuser
// req      | in  | move_x, move_y, move_z, pitch_angle, yaw_angle,      | mode
//          |     | roll_angle (6 x 32)                                  |
// rsp      | out | view_r00..r02, r10..r12, r20..r22, view_tx/ty/tz     | -
//
// A move item computes 9 products for the rotation matrix, 9 for the position update and
// 9 for the view translation, all on the one shared 33x33 multiplier. A rotate item
// runs three CORDIC passes, a square root and, unless the norm is zero, four restoring
// divides, then the rotation matrix and view translation products.
// Reset is synchronous; it puts the camera at the origin with identity orientation.
// req_tready is high only in idle; a result waits in the output register and the next
// item is taken meanwhile, but its result is loaded only after the earlier one leaves.
module camera_pose_view_matrix (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // move_x, move_y, move_z, pitch_angle, yaw_angle, roll_angle
   input  logic [191:0] req_tdata,
   // mode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // view_r00, r01, r02, r10, r11, r12, r20, r21, r22, view_tx, view_ty, view_tz
   output logic [383:0] rsp_tdata
);

   cvm_pkg::state_type state_ff, state_in;
   cvm_pkg::phase_type phase_ff;

   logic               mode_ff;
   logic               half_ff;
   logic [3:0]         n_ff;
   logic [1:0]         i_ff, j_ff;
   logic signed [31:0] q_ff   [4];
   logic signed [31:0] tmp_ff [4];
   logic signed [31:0] qa_ff  [4];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] ang_ff [3];
   logic signed [32:0] tv_ff  [3];
   logic signed [35:0] p_ff   [9];
   logic signed [31:0] m_ff   [9];
   logic signed [31:0] tx_ff  [3];
   logic signed [37:0] acc_ff;
   logic [63:0]        sum_ff;
   logic [31:0]        root_ff;
   logic signed [65:0] mul_ff;
   logic               rsp_valid_ff;
   logic [383:0]       rsp_data_ff;

   logic               req_acc;
   logic               cs_start, sq_start, dv_start;
   cvm_pkg::cs_out_type cs_res;
   cvm_pkg::sq_out_type sq_res;
   cvm_pkg::dv_out_type dv_res;
   logic signed [32:0] op_a, op_b;
   logic signed [65:0] mul_rnd;
   logic signed [35:0] rp;
   cvm_pkg::term_type  qt, rt;
   logic signed [63:0] pe [9];
   logic signed [31:0] mb [9];
   logic signed [37:0] acc_mv, acc_qm, acc_tx;
   logic [31:0]        mag;
   logic [cvm_pkg::DIV_NUM_W-1:0] dv_num;
   logic signed [63:0] qsv;
   logic               rsp_load;

   function automatic logic [3:0] midx(input logic [1:0] r, input logic [1:0] c);
      return 4'({r, 1'b0}) + 4'(r) + 4'(c);
   endfunction

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_load = (state_ff == cvm_pkg::ST_DONE) && !rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cvm_pkg::ST_IDLE:
            if (req_acc)
               state_in = (req_tuser == cvm_pkg::MODE_ROTATE) ? cvm_pkg::ST_CS_START
                                                               : cvm_pkg::ST_RM_MUL;
         cvm_pkg::ST_RM_MUL:
            if (half_ff && n_ff == 4'd8) state_in = cvm_pkg::ST_RM_BUILD;
         cvm_pkg::ST_RM_BUILD:
            state_in = (mode_ff == cvm_pkg::MODE_MOVE) ? cvm_pkg::ST_MV_MAC
                                                       : cvm_pkg::ST_TX_MAC;
         cvm_pkg::ST_MV_MAC:
            if (half_ff && i_ff == 2'd2 && j_ff == 2'd2) state_in = cvm_pkg::ST_TX_MAC;
         cvm_pkg::ST_CS_START: state_in = cvm_pkg::ST_CS_WAIT;
         cvm_pkg::ST_CS_WAIT:
            if (cs_res.done) state_in = cvm_pkg::ST_QM_MAC;
         cvm_pkg::ST_QM_MAC:
            if (half_ff && n_ff == 4'd15)
               state_in = (phase_ff == cvm_pkg::PH_ROLL) ? cvm_pkg::ST_NS_MAC
                                                         : cvm_pkg::ST_CS_START;
         cvm_pkg::ST_NS_MAC:
            if (half_ff && n_ff == 4'd3) state_in = cvm_pkg::ST_SQ_START;
         cvm_pkg::ST_SQ_START: state_in = cvm_pkg::ST_SQ_WAIT;
         cvm_pkg::ST_SQ_WAIT:
            if (sq_res.done)
               state_in = (sq_res.root == '0) ? cvm_pkg::ST_RM_MUL : cvm_pkg::ST_DV_START;
         cvm_pkg::ST_DV_START: state_in = cvm_pkg::ST_DV_WAIT;
         cvm_pkg::ST_DV_WAIT:
            if (dv_res.done)
               state_in = (n_ff == 4'd3) ? cvm_pkg::ST_RM_MUL : cvm_pkg::ST_DV_START;
         cvm_pkg::ST_TX_MAC:
            if (half_ff && i_ff == 2'd2 && j_ff == 2'd2) state_in = cvm_pkg::ST_DONE;
         cvm_pkg::ST_DONE:
            if (!rsp_valid_ff) state_in = cvm_pkg::ST_IDLE;
         default: state_in = cvm_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == cvm_pkg::ST_IDLE);
      cs_start   = (state_ff == cvm_pkg::ST_CS_START);
      sq_start   = (state_ff == cvm_pkg::ST_SQ_START);
      dv_start   = (state_ff == cvm_pkg::ST_DV_START);
   end

   // shared multiplier operands
   assign qt = cvm_pkg::qm_term(n_ff);
   assign rt = cvm_pkg::rm_pair(n_ff);

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         cvm_pkg::ST_RM_MUL: begin
            op_a = 33'(q_ff[rt.ia]);
            op_b = 33'(q_ff[rt.ib]);
         end
         cvm_pkg::ST_MV_MAC: begin
            op_a = 33'(m_ff[midx(i_ff, j_ff)]);
            op_b = tv_ff[j_ff];
         end
         cvm_pkg::ST_QM_MAC: begin
            unique case (phase_ff)
               cvm_pkg::PH_YAW: begin
                  op_a = 33'(qa_ff[qt.ia]);
                  op_b = 33'(q_ff[qt.ib]);
               end
               cvm_pkg::PH_PITCH: begin
                  op_a = 33'(tmp_ff[qt.ia]);
                  op_b = 33'(qa_ff[qt.ib]);
               end
               default: begin
                  op_a = 33'(q_ff[qt.ia]);
                  op_b = 33'(qa_ff[qt.ib]);
               end
            endcase
         end
         cvm_pkg::ST_NS_MAC: begin
            op_a = 33'(tmp_ff[n_ff[1:0]]);
            op_b = 33'(tmp_ff[n_ff[1:0]]);
         end
         cvm_pkg::ST_TX_MAC: begin
            op_a = 33'(m_ff[midx(j_ff, i_ff)]);
            op_b = 33'(pos_ff[j_ff]);
         end
         default: ;
      endcase
   end

   // product rounded half up to Q.30 scale
   assign mul_rnd = mul_ff + 66'sd536870912;
   assign rp      = mul_rnd[65:30];

   always_comb begin
      for (int k = 0; k < 9; k++) pe[k] = 64'(p_ff[k]);
      mb[0] = cvm_pkg::sat32(cvm_pkg::FX_ONE - 64'sd2 * (pe[1] + pe[2]));
      mb[1] = cvm_pkg::sat32(64'sd2 * (pe[3] - pe[8]));
      mb[2] = cvm_pkg::sat32(64'sd2 * (pe[4] + pe[7]));
      mb[3] = cvm_pkg::sat32(64'sd2 * (pe[3] + pe[8]));
      mb[4] = cvm_pkg::sat32(cvm_pkg::FX_ONE - 64'sd2 * (pe[0] + pe[2]));
      mb[5] = cvm_pkg::sat32(64'sd2 * (pe[5] - pe[6]));
      mb[6] = cvm_pkg::sat32(64'sd2 * (pe[4] - pe[7]));
      mb[7] = cvm_pkg::sat32(64'sd2 * (pe[5] + pe[6]));
      mb[8] = cvm_pkg::sat32(cvm_pkg::FX_ONE - 64'sd2 * (pe[0] + pe[1]));
   end

   assign acc_mv = ((j_ff == 2'd0) ? 38'(pos_ff[i_ff]) : acc_ff) + 38'(rp);
   assign acc_qm = ((n_ff[1:0] == 2'd0) ? 38'sd0 : acc_ff) + (qt.neg ? -38'(rp) : 38'(rp));
   assign acc_tx = ((j_ff == 2'd0) ? 38'sd0 : acc_ff) - 38'(rp);

   assign mag    = tmp_ff[n_ff[1:0]][31] ? 32'(-tmp_ff[n_ff[1:0]]) : tmp_ff[n_ff[1:0]];
   assign dv_num = {1'b0, mag, 29'b0} + cvm_pkg::DIV_NUM_W'(root_ff[31:1]);
   assign qsv    = tmp_ff[n_ff[1:0]][31] ? -64'({2'b0, dv_res.quot})
                                         : 64'({2'b0, dv_res.quot});

   cvm_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cs_start),
      .angle (ang_ff[phase_ff]),
      .res   (cs_res)
   );

   cvm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sum_ff),
      .res   (sq_res)
   );

   cvm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (root_ff),
      .res   (dv_res)
   );

   // control and camera state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cvm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ff[0]      <= 32'sd1073741824;
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
         pos_ff[0]    <= '0;
         pos_ff[1]    <= '0;
         pos_ff[2]    <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         if (state_ff == cvm_pkg::ST_MV_MAC && half_ff && j_ff == 2'd2)
            pos_ff[i_ff] <= cvm_pkg::sat32(64'(acc_mv));
         if (state_ff == cvm_pkg::ST_QM_MAC && half_ff && n_ff[1:0] == 2'd3 &&
             phase_ff == cvm_pkg::PH_PITCH)
            q_ff[n_ff[3:2]] <= cvm_pkg::sat32(64'(acc_qm));
         if (state_ff == cvm_pkg::ST_SQ_WAIT && sq_res.done && sq_res.root == '0) begin
            q_ff[0] <= 32'sd1073741824;
            q_ff[1] <= '0;
            q_ff[2] <= '0;
            q_ff[3] <= '0;
         end
         if (state_ff == cvm_pkg::ST_DV_WAIT && dv_res.done)
            q_ff[n_ff[1:0]] <= cvm_pkg::sat32(qsv);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mul_ff <= op_a * op_b;
      unique case (state_ff)
         cvm_pkg::ST_IDLE: begin
            half_ff  <= 1'b0;
            n_ff     <= '0;
            i_ff     <= '0;
            j_ff     <= '0;
            phase_ff <= cvm_pkg::PH_YAW;
            if (req_acc) begin
               mode_ff   <= req_tuser;
               tv_ff[0]  <= 33'(signed'(req_tdata[31:0]));
               tv_ff[1]  <= 33'(signed'(req_tdata[63:32]));
               tv_ff[2]  <= -33'(signed'(req_tdata[95:64]));
               ang_ff[1] <= signed'(req_tdata[127:96]);
               ang_ff[0] <= signed'(req_tdata[159:128]);
               ang_ff[2] <= signed'(req_tdata[191:160]);
            end
         end
         cvm_pkg::ST_RM_MUL: begin
            half_ff <= !half_ff;
            if (half_ff) begin
               p_ff[n_ff] <= rp;
               n_ff       <= (n_ff == 4'd8) ? 4'd0 : n_ff + 4'd1;
            end
         end
         cvm_pkg::ST_RM_BUILD: begin
            for (int k = 0; k < 9; k++) m_ff[k] <= mb[k];
         end
         cvm_pkg::ST_MV_MAC, cvm_pkg::ST_TX_MAC: begin
            half_ff <= !half_ff;
            if (half_ff) begin
               if (state_ff == cvm_pkg::ST_MV_MAC)
                  acc_ff <= acc_mv;
               else begin
                  acc_ff <= acc_tx;
                  if (j_ff == 2'd2) tx_ff[i_ff] <= cvm_pkg::sat32(64'(acc_tx));
               end
               if (j_ff == 2'd2) begin
                  j_ff <= '0;
                  i_ff <= (i_ff == 2'd2) ? 2'd0 : i_ff + 2'd1;
               end else begin
                  j_ff <= j_ff + 2'd1;
               end
            end
         end
         cvm_pkg::ST_CS_WAIT: begin
            if (cs_res.done) begin
               qa_ff[0] <= cs_res.cos_v;
               qa_ff[1] <= (phase_ff == cvm_pkg::PH_PITCH) ? cs_res.sin_v : '0;
               qa_ff[2] <= (phase_ff == cvm_pkg::PH_YAW) ? cs_res.sin_v : '0;
               qa_ff[3] <= (phase_ff == cvm_pkg::PH_ROLL) ? cs_res.sin_v : '0;
            end
         end
         cvm_pkg::ST_QM_MAC: begin
            half_ff <= !half_ff;
            if (half_ff) begin
               acc_ff <= acc_qm;
               n_ff   <= n_ff + 4'd1;
               if (n_ff[1:0] == 2'd3 && phase_ff != cvm_pkg::PH_PITCH)
                  tmp_ff[n_ff[3:2]] <= cvm_pkg::sat32(64'(acc_qm));
               if (n_ff == 4'd15)
                  phase_ff <= (phase_ff == cvm_pkg::PH_YAW) ? cvm_pkg::PH_PITCH
                                                            : cvm_pkg::PH_ROLL;
            end
         end
         cvm_pkg::ST_NS_MAC: begin
            half_ff <= !half_ff;
            if (half_ff) begin
               sum_ff <= ((n_ff == 4'd0) ? 64'd0 : sum_ff) + {2'b00, mul_ff[63:2]};
               n_ff   <= (n_ff == 4'd3) ? 4'd0 : n_ff + 4'd1;
            end
         end
         cvm_pkg::ST_SQ_WAIT: begin
            if (sq_res.done) root_ff <= sq_res.root;
         end
         cvm_pkg::ST_DV_WAIT: begin
            if (dv_res.done) n_ff <= (n_ff == 4'd3) ? 4'd0 : n_ff + 4'd1;
         end
         default: ;
      endcase
      if (rsp_load)
         rsp_data_ff <= {tx_ff[2], tx_ff[1], tx_ff[0], m_ff[8], m_ff[5], m_ff[2],
                         m_ff[7], m_ff[4], m_ff[1], m_ff[6], m_ff[3], m_ff[0]};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/cvm_cordic.sv -----
module cvm_cordic (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [31:0]     angle,
   output cvm_pkg::cs_out_type    res
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         step_ff, step_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [34:0] z_ff, z_in;
   logic               flip_ff, flip_in;
   logic signed [34:0] z0;
   logic signed [33:0] dx, dy;
   logic signed [34:0] at;
   logic signed [33:0] xo, yo;

   assign z0 = {{2{angle[31]}}, angle, 1'b0};
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign at = 35'(cvm_pkg::atan_val(step_ff));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = cvm_pkg::CORDIC_GAIN;
         y_in    = '0;
         if (z0 > cvm_pkg::HALF_PI_Q30) begin
            z_in    = z0 - cvm_pkg::PI_Q30;
            flip_in = 1'b1;
         end else if (z0 < -cvm_pkg::HALF_PI_Q30) begin
            z_in    = z0 + cvm_pkg::PI_Q30;
            flip_in = 1'b1;
         end else begin
            z_in    = z0;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[34]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(cvm_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign xo = flip_ff ? -x_ff : x_ff;
   assign yo = flip_ff ? -y_ff : y_ff;

   assign res.done  = done_ff;
   assign res.cos_v = xo[31:0];
   assign res.sin_v = yo[31:0];

endmodule

// ----- rtl/cvm_isqrt.sv -----
module cvm_isqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         value,
   output cvm_pkg::sq_out_type res
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         n_in    = value;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign res.done = done_ff;
   assign res.root = res_ff[31:0];

endmodule

// ----- rtl/cvm_div.sv -----
module cvm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cvm_pkg::DIV_NUM_W-1:0]       num,
   input  logic [31:0]                         den,
   output cvm_pkg::dv_out_type                 res
);

   localparam int NW = cvm_pkg::DIV_NUM_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [31:0]   rem_ff, rem_in, den_ff, den_in;
   logic [NW-1:0] q_ff, q_in;
   logic [32:0]   trial;
   logic          ge;

   // restoring division: numerator shifts out the top, quotient bits in the bottom
   assign trial = {rem_ff, q_ff[NW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         q_in   = {q_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign res.done = done_ff;
   assign res.quot = q_ff;

endmodule

// ----- rtl/cvm_checker.sv -----
`include "camera_pose_view_matrix_defines.svh"

module cvm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [383:0] rsp_tdata
);

   `CVM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `CVM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `CVM_ASSERT_NEXT(a_no_back_to_back_rsp, rsp_tvalid && rsp_tready, !rsp_tvalid)
   `CVM_ASSERT_AFTER_RESET(a_reset_empty, !rsp_tvalid && req_tready)

endmodule

bind camera_pose_view_matrix cvm_checker u_cvm_checker (.*);
